/* hdl/pjq_pkg.sv */
// pjq_pkg: shared types, widths and codes of the print job priority queue
// no dependencies; imported by every other file of the block but pjq_ram

package pjq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int NUM_W      = 16;
	localparam int PAGE_W     = 16;
	localparam int KIND_W     = 8;
	localparam int URG_W      = 8;
	localparam int SPEED_W    = 8;
	localparam int DEADLINE_W = 16;
	localparam int TIME_W     = 16;
	localparam int OCC_W      = 5;
	localparam int STATUS_W   = 3;
	localparam int KEY_W      = URG_W + PAGE_W;
	localparam int LIMIT_W    = SPEED_W + DEADLINE_W;

	localparam int DIV_STEPS = PAGE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADLINE = 1'b1;

	localparam logic [SPEED_W-1:0]    SPEED_RESET    = 8'd1;
	localparam logic [DEADLINE_W-1:0] DEADLINE_RESET = 16'd22;

	localparam logic CMD_SUBMIT   = 1'b0;
	localparam logic CMD_DISPATCH = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPTED = 3'd0,
		ST_FULL     = 3'd1,
		ST_OK       = 3'd2,
		ST_LATE     = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_LIMIT,
		S_DIVIDE,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [NUM_W-1:0]  number;
		logic [PAGE_W-1:0] pages;
		logic [KIND_W-1:0] kind;
		logic [URG_W-1:0]  urgency;
	} job_t;

	localparam int JOB_W = $bits(job_t);

	typedef struct packed {
		status_t           status;
		job_t              job;
		logic [TIME_W-1:0] ptime;
		logic [OCC_W-1:0]  occupancy;
	} result_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [JOB_W-1:0]  wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

endpackage

/* hdl/pjq_job_if.sv */
// pjq_job_if: input command channel (valid, ready, submit or dispatch fields)
// depends on pjq_pkg

interface pjq_job_if
	import pjq_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              command;
	logic [NUM_W-1:0]  job_number;
	logic [PAGE_W-1:0] page_count;
	logic [KIND_W-1:0] job_kind;
	logic [URG_W-1:0]  urgency;

	modport source (output valid, command, job_number, page_count, job_kind, urgency,
		input ready);
	modport sink (input valid, command, job_number, page_count, job_kind, urgency,
		output ready);
endinterface

/* hdl/pjq_result_if.sv */
// pjq_result_if: result channel, one item per command
// depends on pjq_pkg

interface pjq_result_if
	import pjq_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [NUM_W-1:0]    out_job_number;
	logic [PAGE_W-1:0]   out_page_count;
	logic [KIND_W-1:0]   out_job_kind;
	logic [URG_W-1:0]    out_urgency;
	logic [TIME_W-1:0]   print_time;
	logic [OCC_W-1:0]    occupancy;

	modport source (output valid, status, out_job_number, out_page_count, out_job_kind,
		out_urgency, print_time, occupancy, input ready);
	modport sink (input valid, status, out_job_number, out_page_count, out_job_kind,
		out_urgency, print_time, occupancy, output ready);
endinterface

/* hdl/pjq_cfg_if.sv */
// pjq_cfg_if: configuration write channel (register index and data)
// depends on pjq_pkg

interface pjq_cfg_if
	import pjq_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/print_job_priority_queue.sv */
// print_job_priority_queue: top level; config registers, output register, instances
// depends on pjq_pkg, pjq_job_if, pjq_result_if, pjq_cfg_if, pjq_ram, pjq_divider, pjq_ctrl

// Bounded print job queue of QUEUE_DEPTH entries. A submit item stores the job in
// arrival order (or is refused when full). A dispatch item removes the held job
// with the lowest urgency, then fewest pages, then earliest arrival: the scan and
// the compaction read the job RAM one entry per cycle through its single read
// port, and the print time comes from a serial divider of 16 steps (skipped when
// the job is over its deadline). A dispatch on an empty queue goes straight to
// its result. One item is worked on at a time; the next is taken while a finished
// result still waits in the output register. Configuration writes are taken
// every cycle.

module print_job_priority_queue
	import pjq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	pjq_job_if.sink      job,
	pjq_result_if.source result,
	pjq_cfg_if.sink      cfg
);
	logic [SPEED_W-1:0]    speed_q;
	logic [DEADLINE_W-1:0] deadline_q;
	logic                  out_valid_q;
	result_t               out_q;

	job_t               job_in;
	ram_req_t           ram_req;
	logic [JOB_W-1:0]   ram_rdata;
	logic               div_start;
	logic [PAGE_W-1:0]  div_dividend;
	logic [SPEED_W-1:0] div_divisor;
	logic               div_busy;
	logic               div_done;
	logic [TIME_W-1:0]  div_quotient;
	logic               out_free;
	logic               res_valid;
	result_t            res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q    <= SPEED_RESET;
			deadline_q <= DEADLINE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SPEED:    speed_q    <= cfg.data[SPEED_W-1:0];
				CFG_DEADLINE: deadline_q <= cfg.data[DEADLINE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign job_in.number  = job.job_number;
	assign job_in.pages   = job.page_count;
	assign job_in.kind    = job.job_kind;
	assign job_in.urgency = job.urgency;

	pjq_ram #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	pjq_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quotient)
	);

	pjq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job.valid),
		.job_ready    (job.ready),
		.command      (job.command),
		.job_in       (job_in),
		.speed        (speed_q),
		.deadline     (deadline_q),
		.ram_req      (ram_req),
		.ram_rdata    (ram_rdata),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_busy     (div_busy),
		.div_done     (div_done),
		.div_quotient (div_quotient),
		.out_free     (out_free),
		.res_valid    (res_valid),
		.res          (res)
	);

	// output slot frees in the same cycle the waiting item is taken
	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.status         = out_q.status;
	assign result.out_job_number = out_q.job.number;
	assign result.out_page_count = out_q.job.pages;
	assign result.out_job_kind   = out_q.job.kind;
	assign result.out_urgency    = out_q.job.urgency;
	assign result.print_time     = out_q.ptime;
	assign result.occupancy      = out_q.occupancy;
endmodule

/* hdl/pjq_ram.sv */
// pjq_ram: generic single write port, single read port RAM with registered read
// no dependencies

module pjq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* hdl/pjq_divider.sv */
// pjq_divider: serial restoring divider, one quotient bit per cycle, rounds up
// depends on pjq_pkg

module pjq_divider
	import pjq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [PAGE_W-1:0]  dividend,
	input  logic [SPEED_W-1:0] divisor,
	output logic               busy,
	output logic               done,
	output logic [TIME_W-1:0]  quotient
);
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [PAGE_W-1:0]    num_q;
	logic [SPEED_W-1:0]   rem_q;
	logic [SPEED_W-1:0]   div_q;

	logic [SPEED_W:0]   trial;
	logic [SPEED_W+1:0] diff;
	logic               ge;

	assign trial = {rem_q, num_q[PAGE_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, div_q};
	assign ge    = ~diff[SPEED_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// dividend shifts out on top while quotient bits enter below
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[PAGE_W-2:0], ge};
			rem_q <= ge ? diff[SPEED_W-1:0] : trial[SPEED_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = num_q + TIME_W'(rem_q != '0);
endmodule

/* hdl/pjq_ctrl.sv */
// pjq_ctrl: command sequencer; submit, best-key scan, compaction, deadline check
// depends on pjq_pkg; drives pjq_ram and pjq_divider through the top level

module pjq_ctrl
	import pjq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  job_valid,
	output logic                  job_ready,
	input  logic                  command,
	input  job_t                  job_in,
	input  logic [SPEED_W-1:0]    speed,
	input  logic [DEADLINE_W-1:0] deadline,
	output ram_req_t              ram_req,
	input  logic [JOB_W-1:0]      ram_rdata,
	output logic                  div_start,
	output logic [PAGE_W-1:0]     div_dividend,
	output logic [SPEED_W-1:0]    div_divisor,
	input  logic                  div_busy,
	input  logic                  div_done,
	input  logic [TIME_W-1:0]     div_quotient,
	input  logic                  out_free,
	output logic                  res_valid,
	output result_t               res
);
	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   ptr_q;
	logic               rd_valid_q;
	logic [ADDR_W-1:0]  best_idx_q;
	logic [KEY_W-1:0]   best_key_q;
	job_t               best_job_q;
	result_t            res_q;

	job_t               rd_job;
	logic [KEY_W-1:0]   rd_key;
	logic               accept;
	logic               full;
	logic               scan_take;
	logic [ADDR_W-1:0]  scan_idx;
	logic [ADDR_W-1:0]  scan_best;
	logic               ptr_more;
	logic [SPEED_W-1:0] speed_eff;
	logic [LIMIT_W-1:0] limit;
	logic               over;

	assign rd_job    = job_t'(ram_rdata);
	assign rd_key    = {rd_job.urgency, rd_job.pages};
	assign accept    = job_valid && job_ready;
	assign full      = (count_q >= CNT_W'(QUEUE_DEPTH));
	assign ptr_more  = (ptr_q < count_q);
	assign scan_idx  = ADDR_W'(ptr_q - CNT_W'(1));
	// strict less keeps the earliest arrival among equal keys
	assign scan_take = (state_q == S_SCAN) && rd_valid_q
		&& ((ptr_q == CNT_W'(1)) || (rd_key < best_key_q));
	assign scan_best = scan_take ? scan_idx : best_idx_q;
	assign speed_eff = (speed == '0) ? SPEED_W'(1) : speed;
	assign limit     = LIMIT_W'(speed_eff) * LIMIT_W'(deadline);
	assign over      = (LIMIT_W'(best_job_q.pages) > limit);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (job_valid) begin
					if (command == CMD_SUBMIT || count_q == '0) begin
						state_d = S_EMIT;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (rd_valid_q && ptr_q == count_q) begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (!rd_valid_q && !ptr_more) begin
					state_d = S_LIMIT;
				end
			end
			S_LIMIT: begin
				state_d = over ? S_EMIT : S_DIVIDE;
			end
			S_DIVIDE: begin
				if (div_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		job_ready     = (state_q == S_IDLE);
		ram_req.we    = 1'b0;
		ram_req.waddr = count_q[ADDR_W-1:0];
		ram_req.wdata = JOB_W'(job_in);
		ram_req.raddr = ptr_q[ADDR_W-1:0];
		div_start     = 1'b0;
		res_valid     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				ram_req.we = accept && (command == CMD_SUBMIT) && !full;
			end
			S_SHIFT: begin
				// entry read last cycle moves one place down
				ram_req.we    = rd_valid_q;
				ram_req.waddr = ADDR_W'(ptr_q - CNT_W'(2));
				ram_req.wdata = ram_rdata;
			end
			S_LIMIT: begin
				div_start = !over;
			end
			S_EMIT: begin
				res_valid = out_free;
			end
			S_SCAN, S_DIVIDE: begin
			end
			default: begin
			end
		endcase
	end

	assign div_dividend = best_job_q.pages;
	assign div_divisor  = speed_eff;
	assign res          = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			ptr_q      <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					ptr_q      <= '0;
					rd_valid_q <= 1'b0;
					if (accept && command == CMD_SUBMIT && !full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				S_SCAN, S_SHIFT: begin
					rd_valid_q <= ptr_more;
					if (state_d == S_SHIFT && state_q == S_SCAN) begin
						ptr_q <= CNT_W'(scan_best) + CNT_W'(1);
					end else if (ptr_more) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
				end
				S_LIMIT: begin
					count_q <= count_q - CNT_W'(1);
				end
				S_DIVIDE, S_EMIT: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (scan_take) begin
			best_idx_q <= scan_idx;
			best_key_q <= rd_key;
			best_job_q <= rd_job;
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_q.ptime <= '0;
					if (command == CMD_SUBMIT) begin
						res_q.job <= job_in;
						if (full) begin
							res_q.status    <= ST_FULL;
							res_q.occupancy <= OCC_W'(count_q);
						end else begin
							res_q.status    <= ST_ACCEPTED;
							res_q.occupancy <= OCC_W'(count_q + CNT_W'(1));
						end
					end else begin
						res_q.status    <= ST_EMPTY;
						res_q.job       <= '0;
						res_q.occupancy <= OCC_W'(count_q);
					end
				end
			end
			S_LIMIT: begin
				res_q.job       <= best_job_q;
				res_q.occupancy <= OCC_W'(count_q - CNT_W'(1));
				res_q.status    <= ST_LATE;
				res_q.ptime     <= '0;
			end
			S_DIVIDE: begin
				if (div_done) begin
					res_q.status <= ST_OK;
					res_q.ptime  <= div_quotient;
				end
			end
			S_SCAN, S_SHIFT, S_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("held count above queue depth");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && ram_req.we) |-> (CNT_W'(ram_req.waddr) < count_q))
		else $error("compaction writes past the held entries");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && state_d == S_SCAN) |=> (count_q != '0))
		else $error("scan entered on an empty queue");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_free)
		else $error("result issued while the output slot is taken");
endmodule

/* test/pjq_checker.sv */
// pjq_checker: watches the command, result and config channels of the print job queue,
// predicts each result from its own copy of the job store and compares in order
// depends on pjq_pkg, pjq_job_if, pjq_result_if, pjq_cfg_if
`timescale 1ns / 1ps

module pjq_checker
	import pjq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	pjq_job_if    job,
	pjq_result_if result,
	pjq_cfg_if    cfg,
	output int    fail_count,
	output int    outstanding
);

	job_t                  held_jobs[$];
	result_t               due_results[$];
	logic [SPEED_W-1:0]    speed_reg;
	logic [DEADLINE_W-1:0] deadline_reg;

	function automatic result_t queue_command(input logic cmd, input job_t incoming);
		result_t          r;
		int               best;
		logic [KEY_W-1:0] best_key;
		logic [KEY_W-1:0] cand_key;
		job_t             pick;
		int               spd;
		int               limit;
		r = '0;
		if (cmd == CMD_SUBMIT) begin
			r.job = incoming;
			if (held_jobs.size() < QUEUE_DEPTH) begin
				held_jobs.push_back(incoming);
				r.status = ST_ACCEPTED;
			end else begin
				r.status = ST_FULL;
			end
		end else if (held_jobs.size() == 0) begin
			r.status = ST_EMPTY;
		end else begin
			// lowest urgency, then fewest pages; strict less keeps arrival order on ties
			best = 0;
			best_key = {held_jobs[0].urgency, held_jobs[0].pages};
			for (int i = 1; i < held_jobs.size(); i++) begin
				cand_key = {held_jobs[i].urgency, held_jobs[i].pages};
				if (cand_key < best_key) begin
					best_key = cand_key;
					best = i;
				end
			end
			pick = held_jobs[best];
			held_jobs.delete(best);
			spd = (speed_reg == '0) ? 1 : int'(speed_reg);
			limit = spd * int'(deadline_reg);
			r.job = pick;
			if (int'(pick.pages) > limit) begin
				r.status = ST_LATE;
			end else begin
				r.status = ST_OK;
				r.ptime = TIME_W'((int'(pick.pages) + spd - 1) / spd);
			end
		end
		r.occupancy = OCC_W'(held_jobs.size());
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		job_t    incoming;
		if (!arst_n) begin
			held_jobs.delete();
			due_results.delete();
			speed_reg = SPEED_RESET;
			deadline_reg = DEADLINE_RESET;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_SPEED:    speed_reg = cfg.data[SPEED_W-1:0];
					CFG_DEADLINE: deadline_reg = cfg.data[DEADLINE_W-1:0];
					default:      ;
				endcase
			end
			if (result.valid && result.ready) begin
				got.status = status_t'(result.status);
				got.job = {result.out_job_number, result.out_page_count, result.out_job_kind,
					result.out_urgency};
				got.ptime = result.print_time;
				got.occupancy = result.occupancy;
				if (due_results.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result status %0d job %h time %0d occ %0d",
							$realtime, got.status, got.job, got.ptime, got.occupancy);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					if (got !== want) begin
						if (fail_count < 10) begin
							$display("%0t: mismatch exp status %0d num %h pages %h kind %h urg %h time %0d occ %0d",
								$realtime, want.status, want.job.number, want.job.pages,
								want.job.kind, want.job.urgency, want.ptime, want.occupancy);
							$display("%0t:          got status %0d num %h pages %h kind %h urg %h time %0d occ %0d",
								$realtime, got.status, got.job.number, got.job.pages,
								got.job.kind, got.job.urgency, got.ptime, got.occupancy);
						end
						fail_count++;
					end
				end
			end
			if (job.valid && job.ready) begin
				incoming = {job.job_number, job.page_count, job.job_kind, job.urgency};
				due_results.push_back(queue_command(job.command, incoming));
			end
		end
		outstanding = due_results.size();
	end

endmodule

/* test/tb_print_job_priority_queue.sv */
// tb_print_job_priority_queue: drives commands and config writes into the print job queue
// under several idle and stall mixes; verdict comes from the failure count of pjq_checker
// depends on pjq_pkg, the channel interfaces, print_job_priority_queue and pjq_checker
`timescale 1ns / 1ps

module tb_print_job_priority_queue;
	import pjq_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int HOLDOFF_LEN   = 300;
	localparam int BURST_LEN     = 23;
	localparam int BURSTS        = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   outstanding;
	int   cycle_count = 0;
	int   sender_idle = 0;
	int   recv_stall = 0;
	int   holdoff_requests = 0;
	int   page_span = 44;
	logic [SPEED_W-1:0]    cur_speed = SPEED_RESET;
	logic [DEADLINE_W-1:0] cur_deadline = DEADLINE_RESET;

	pjq_job_if    job();
	pjq_result_if result();
	pjq_cfg_if    cfg();

	print_job_priority_queue u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.job    (job),
		.result (result),
		.cfg    (cfg)
	);

	pjq_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (job),
		.result      (result),
		.cfg         (cfg),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("print_job_priority_queue test failed");
			$finish;
		end
	end

	// result side: random stalls, plus long hold-offs on request
	initial begin : receiver
		int hold_left;
		int served;
		hold_left = 0;
		served = 0;
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (served != holdoff_requests) begin
				served++;
				hold_left = HOLDOFF_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				result.ready = 1'b0;
			end else begin
				result.ready = ($urandom_range(99) >= recv_stall);
			end
		end
	end

	task automatic offer_job(input logic cmd, input logic [NUM_W-1:0] num,
		input logic [PAGE_W-1:0] pages, input logic [KIND_W-1:0] kind,
		input logic [URG_W-1:0] urg);
		while ($urandom_range(99) < sender_idle) begin
			job.valid = 1'b0;
			@(negedge clk);
		end
		job.valid = 1'b1;
		job.command = cmd;
		job.job_number = num;
		job.page_count = pages;
		job.job_kind = kind;
		job.urgency = urg;
		do @(posedge clk); while (!job.ready);
		@(negedge clk);
	endtask

	task automatic settle();
		job.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		int spd;
		int limit;
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data = val;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
		if (idx == CFG_SPEED)
			cur_speed = val[SPEED_W-1:0];
		else
			cur_deadline = val[DEADLINE_W-1:0];
		// keep one half of the random page counts near the deadline limit
		spd = (cur_speed == '0) ? 1 : int'(cur_speed);
		limit = spd * int'(cur_deadline);
		page_span = (2 * limit + 2 > 65535) ? 65535 : 2 * limit + 2;
	endtask

	task automatic random_burst();
		int                submit_pct;
		logic              cmd;
		logic [PAGE_W-1:0] pages;
		logic [URG_W-1:0]  urg;
		case ($urandom_range(2))
			0:       submit_pct = 80;
			1:       submit_pct = 50;
			default: submit_pct = 25;
		endcase
		for (int i = 0; i < BURST_LEN; i++) begin
			cmd = ($urandom_range(99) < submit_pct) ? CMD_SUBMIT : CMD_DISPATCH;
			pages = $urandom_range(1) ? PAGE_W'($urandom_range(page_span)) : PAGE_W'($urandom);
			// narrow urgencies make ties on the first key common
			urg = $urandom_range(1) ? URG_W'($urandom_range(3)) : URG_W'($urandom);
			offer_job(cmd, NUM_W'($urandom), pages, KIND_W'($urandom), urg);
		end
	endtask

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] speed_val;
		logic [CFG_DATA_W-1:0] deadline_val;
		job.valid = 1'b0;
		job.command = CMD_SUBMIT;
		job.job_number = '0;
		job.page_count = '0;
		job.job_kind = '0;
		job.urgency = '0;
		cfg.valid = 1'b0;
		cfg.index = CFG_SPEED;
		cfg.data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty dispatch, fill to the brim, refused submit, partly drain through ties
		offer_job(CMD_DISPATCH, 16'hffff, 16'hffff, 8'hff, 8'hff);
		offer_job(CMD_SUBMIT, 16'd0, 16'd22, 8'h11, 8'd5);
		offer_job(CMD_SUBMIT, 16'd1, 16'd23, 8'h22, 8'd5);
		offer_job(CMD_SUBMIT, 16'd2, 16'd10, 8'h33, 8'd5);
		offer_job(CMD_SUBMIT, 16'd3, 16'd10, 8'h44, 8'd5);
		offer_job(CMD_SUBMIT, 16'hffff, 16'd0, 8'hff, 8'd0);
		offer_job(CMD_SUBMIT, 16'd5, 16'hffff, 8'h55, 8'd0);
		offer_job(CMD_SUBMIT, 16'd0, 16'd0, 8'h00, 8'hff);
		offer_job(CMD_SUBMIT, 16'hffff, 16'hffff, 8'hff, 8'hff);
		for (int i = 8; i < QUEUE_DEPTH; i++)
			offer_job(CMD_SUBMIT, NUM_W'(i), PAGE_W'(i * 3), KIND_W'(i), URG_W'(7 + i % 2));
		offer_job(CMD_SUBMIT, 16'h1234, 16'h00ff, 8'h55, 8'd1);
		for (int i = 0; i < 7; i++)
			offer_job(CMD_DISPATCH, NUM_W'($urandom), PAGE_W'($urandom), KIND_W'($urandom),
				URG_W'($urandom));

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0:       begin speed_val = 16'd1;     deadline_val = 16'd1;     end
				1:       begin speed_val = 16'd255;   deadline_val = 16'd65535; end
				2:       begin speed_val = 16'd3;     deadline_val = 16'd22;    end
				3:       begin speed_val = 16'd0;     deadline_val = 16'd50;    end
				4:       begin speed_val = 16'h0107;  deadline_val = 16'd0;     end
				5:       begin speed_val = 16'd2;     deadline_val = 16'd300;   end
				6:       begin speed_val = 16'd255;   deadline_val = 16'd1;     end
				default: begin speed_val = 16'd10;    deadline_val = 16'd40000; end
			endcase
			settle();
			write_reg(CFG_SPEED, speed_val);
			write_reg(CFG_DEADLINE, deadline_val);
			case (phase % 4)
				0:       begin sender_idle = 0;  recv_stall = 0;  end
				1:       begin sender_idle = 64; recv_stall = 0;  end
				2:       begin sender_idle = 0;  recv_stall = 64; end
				default: begin sender_idle = 17; recv_stall = 17; end
			endcase
			for (int b = 0; b < BURSTS; b++) begin
				// long receiver hold-off while commands keep coming, to back up the input
				if ((phase == 0 || phase == 5) && b == 4)
					holdoff_requests++;
				random_burst();
			end
		end

		job.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("print_job_priority_queue test passed");
		else
			$display("print_job_priority_queue test failed");
		$finish;
	end

endmodule
